[design/chc_pkg.sv]
package chc_pkg;

   // Default sample width and fixed widths of the heading search
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int DEG_W           = 7;
   localparam int TAB_N           = 1 << DEG_W;
   localparam int BIT_W           = 3;
   localparam int Q_W             = 64;
   localparam int HALF_W          = Q_W / 2;
   localparam int HEAD_W          = 9;

   // Highest degree held in the trig tables
   localparam logic [DEG_W-1:0] LAST_DEG = 7'd89;

   // Heading constants
   localparam logic [HEAD_W-1:0] DEG_0   = 9'd0;
   localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
   localparam logic [HEAD_W-1:0] DEG_179 = 9'd179;
   localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
   localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
   localparam logic [HEAD_W-1:0] DEG_359 = 9'd359;
   localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

   // Pi with 62 fractional bits
   localparam logic [Q_W-1:0] PI_Q62 = 64'hC90FDAA22168C234;

   typedef logic [Q_W-1:0] q62_type;
   typedef logic [TAB_N-1:0][Q_W-1:0] trig_tab_type;

   // One degree in Q62 radians
   localparam q62_type STEP_Q62 = PI_Q62 / 64'd180;

   // Command and status between controller and datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic delta;
      logic fetch;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic load_out;
   } chc_cmd_type;

   typedef struct packed {
      logic last_probe;
   } chc_stat_type;

   // Q62 product, modulo 2^64
   function automatic q62_type q62_mul(q62_type a, q62_type b);
      logic [2*Q_W-1:0] p;
      p = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b};
      return p[Q_W+61:62];
   endfunction

   // Unsigned quotient by restoring long division, elaboration only
   function automatic q62_type q62_div(q62_type n, q62_type d);
      logic [Q_W:0] r;
      q62_type      q;
      r = '0;
      q = '0;
      for (int i = Q_W - 1; i >= 0; i--) begin
         r = {r[Q_W-1:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sine by Taylor series in Q62, elaboration only
   function automatic q62_type q62_sin(q62_type x);
      q62_type x2;
      q62_type term;
      q62_type sum;
      x2   = q62_mul(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k < 40; k++) begin
         if (term != '0) begin
            term = q62_div(q62_mul(term, x2), q62_type'((2 * k) * (2 * k + 1)));
            if (k[0]) sum = sum - term;
            else sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Build the sine or cosine table for whole degrees 0..89
   function automatic trig_tab_type build_tab(logic cos_sel);
      trig_tab_type t;
      t = '0;
      for (int d = 0; d <= int'(LAST_DEG); d++) begin
         if (cos_sel) t[d] = q62_sin(STEP_Q62 * q62_type'(int'(LAST_DEG) + 1 - d));
         else t[d] = q62_sin(STEP_Q62 * q62_type'(d));
      end
      return t;
   endfunction

   localparam trig_tab_type SIN_TAB = build_tab(1'b0);
   localparam trig_tab_type COS_TAB = build_tab(1'b1);

endpackage

[design/chc_channels.sv]
interface chc_req_if import chc_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_sample;
   logic signed [SAMPLE_BITS-1:0] y_sample;

   modport source (output valid, output x_sample, output y_sample, input ready);
   modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface chc_rsp_if import chc_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic        [HEAD_W-1:0]      heading_deg;
   logic signed [SAMPLE_BITS-1:0] x_offset;
   logic signed [SAMPLE_BITS-1:0] y_offset;

   modport source (output valid, output heading_deg, output x_offset, output y_offset,
                   input ready);
   modport sink   (input valid, input heading_deg, input x_offset, input y_offset,
                   output ready);
endinterface

[design/chc_ctrl.sv]
module chc_ctrl import chc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output chc_cmd_type  cmd,
   input  chc_stat_type stat
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PREP   = 8'b0000_0010,
      ST_DELTA  = 8'b0000_0100,
      ST_FETCH  = 8'b0000_1000,
      ST_MUL_LO = 8'b0001_0000,
      ST_MUL_HI = 8'b0010_0000,
      ST_ACC    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } chc_state_type;

   chc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // Output register is free when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one transaction through the datapath
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DELTA;
         ST_DELTA:  state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_ACC;
         ST_ACC:    state_in = stat.last_probe ? ST_FINISH : ST_FETCH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Decode commands
   always_comb begin
      cmd.load     = req_valid && (state_ff == ST_IDLE);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.delta    = (state_ff == ST_DELTA);
      cmd.fetch    = (state_ff == ST_FETCH);
      cmd.mul_lo   = (state_ff == ST_MUL_LO);
      cmd.mul_hi   = (state_ff == ST_MUL_HI);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.load_out = (state_ff == ST_FINISH) && out_free;
   end

   // Set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/chc_datapath.sv]
module chc_datapath import chc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chc_cmd_type                   cmd,
   output chc_stat_type                  stat,
   input  logic signed [SAMPLE_BITS-1:0] x_sample,
   input  logic signed [SAMPLE_BITS-1:0] y_sample,
   output logic        [HEAD_W-1:0]      heading_deg,
   output logic signed [SAMPLE_BITS-1:0] x_offset,
   output logic signed [SAMPLE_BITS-1:0] y_offset
);

   localparam int MAG_W  = SAMPLE_BITS + 1;
   localparam int PROD_W = MAG_W + HALF_W;
   localparam int DIFF_W = PROD_W + 1;
   localparam int ACC_W  = PROD_W + HALF_W + 2;

   // Calibration state
   logic                          seeded_ff, seeded_in;
   logic signed [SAMPLE_BITS-1:0] x_max_ff, x_max_in, x_min_ff, x_min_in;
   logic signed [SAMPLE_BITS-1:0] y_max_ff, y_max_in, y_min_ff, y_min_in;
   logic signed [SAMPLE_BITS-1:0] base_x_max, base_x_min, base_y_max, base_y_min;

   // Sample, offsets and vector
   logic signed [SAMPLE_BITS-1:0] xs_ff, ys_ff;
   logic signed [SAMPLE_BITS-1:0] xoff_ff, xoff_in, yoff_ff, yoff_in;
   logic signed [MAG_W-1:0]       x_sum, y_sum, x_adj, y_adj, dx, dy;
   logic        [MAG_W-1:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic                          dx_neg_ff, dy_neg_ff, dx_zero_ff, dy_zero_ff;

   // Degree search
   logic [DEG_W-1:0]  lo_ff, lo_in, cand, cand_ff;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              eq_ff, eq_in, cand_ok_ff;
   q62_type           c_ff, s_ff;
   logic [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [DIFF_W-1:0] acc_lo_ff, diff_lo, diff_hi;
   logic signed [ACC_W-1:0]  d_full;
   logic              take;

   // Result
   logic [HEAD_W-1:0] f_deg, heading_in, heading_ff;
   logic signed [SAMPLE_BITS-1:0] x_offset_ff, y_offset_ff;

   // Seed on the first sample, then widen the extremes
   always_comb begin
      base_x_max = seeded_ff ? x_max_ff : x_sample;
      base_x_min = seeded_ff ? x_min_ff : x_sample;
      base_y_max = seeded_ff ? y_max_ff : y_sample;
      base_y_min = seeded_ff ? y_min_ff : y_sample;
      seeded_in  = seeded_ff;
      x_max_in   = x_max_ff;
      x_min_in   = x_min_ff;
      y_max_in   = y_max_ff;
      y_min_in   = y_min_ff;
      if (cmd.load) begin
         seeded_in = 1'b1;
         x_max_in  = base_x_max;
         x_min_in  = base_x_min;
         y_max_in  = base_y_max;
         y_min_in  = base_y_min;
         if (x_sample > base_x_max) x_max_in = x_sample;
         else if (x_sample < base_x_min) x_min_in = x_sample;
         if (y_sample > base_y_max) y_max_in = y_sample;
         else if (y_sample < base_y_min) y_min_in = y_sample;
      end
   end

   // Midpoint of the extremes, truncated toward zero
   always_comb begin
      x_sum   = MAG_W'(x_max_ff) + MAG_W'(x_min_ff);
      y_sum   = MAG_W'(y_max_ff) + MAG_W'(y_min_ff);
      x_adj   = x_sum + (x_sum[MAG_W-1] ? MAG_W'(1) : MAG_W'(0));
      y_adj   = y_sum + (y_sum[MAG_W-1] ? MAG_W'(1) : MAG_W'(0));
      xoff_in = x_adj[MAG_W-1:1];
      yoff_in = y_adj[MAG_W-1:1];
   end

   // Corrected vector and its magnitudes
   always_comb begin
      dx    = MAG_W'(xs_ff) - MAG_W'(xoff_ff);
      dy    = MAG_W'(ys_ff) - MAG_W'(yoff_ff);
      ax_in = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ay_in = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
   end

   // Next probe degree: current floor plus the bit under test
   assign cand = lo_ff | (DEG_W'(1) << bit_ff);
   assign stat.last_probe = (bit_ff == '0);

   // Shared multiplier pair: low halves, then high halves
   always_comb begin
      p1_in = p1_ff;
      p2_in = p2_ff;
      if (cmd.mul_lo) begin
         p1_in = PROD_W'(ay_ff) * PROD_W'(c_ff[HALF_W-1:0]);
         p2_in = PROD_W'(ax_ff) * PROD_W'(s_ff[HALF_W-1:0]);
      end else if (cmd.mul_hi) begin
         p1_in = PROD_W'(ay_ff) * PROD_W'(c_ff[Q_W-1:HALF_W]);
         p2_in = PROD_W'(ax_ff) * PROD_W'(s_ff[Q_W-1:HALF_W]);
      end
   end

   // Sign of ay*cos - ax*sin decides the probe
   always_comb begin
      diff_lo = DIFF_W'(p1_ff) - DIFF_W'(p2_ff);
      diff_hi = DIFF_W'(p1_ff) - DIFF_W'(p2_ff);
      d_full  = (ACC_W'(diff_hi) << HALF_W) + ACC_W'(acc_lo_ff);
      take    = cand_ok_ff && !d_full[ACC_W-1];
      lo_in   = lo_ff;
      eq_in   = eq_ff;
      bit_in  = bit_ff;
      if (cmd.delta) begin
         lo_in  = '0;
         eq_in  = 1'b0;
         bit_in = BIT_W'(DEG_W - 1);
      end else if (cmd.acc) begin
         bit_in = bit_ff - BIT_W'(1);
         if (take) begin
            lo_in = cand_ff;
            eq_in = (d_full == '0);
         end
      end
   end

   // Fold the angle into its quadrant
   always_comb begin
      f_deg = HEAD_W'(lo_ff);
      if (dx_zero_ff) heading_in = (!dy_neg_ff && !dy_zero_ff) ? DEG_90 : DEG_270;
      else if (dy_zero_ff) heading_in = dx_neg_ff ? DEG_180 : DEG_0;
      else if (!dx_neg_ff && !dy_neg_ff) heading_in = f_deg;
      else if (dx_neg_ff && !dy_neg_ff) heading_in = (eq_ff ? DEG_180 : DEG_179) - f_deg;
      else if (dx_neg_ff) heading_in = DEG_180 + f_deg;
      else heading_in = (eq_ff ? DEG_360 : DEG_359) - f_deg;
   end

   // Calibration state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         x_max_ff  <= '0;
         x_min_ff  <= '0;
         y_max_ff  <= '0;
         y_min_ff  <= '0;
      end else begin
         seeded_ff <= seeded_in;
         x_max_ff  <= x_max_in;
         x_min_ff  <= x_min_in;
         y_max_ff  <= y_max_in;
         y_min_ff  <= y_min_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff <= x_sample;
         ys_ff <= y_sample;
      end
      if (cmd.prep) begin
         xoff_ff <= xoff_in;
         yoff_ff <= yoff_in;
      end
      if (cmd.delta) begin
         ax_ff      <= ax_in;
         ay_ff      <= ay_in;
         dx_neg_ff  <= dx[MAG_W-1];
         dy_neg_ff  <= dy[MAG_W-1];
         dx_zero_ff <= (dx == '0);
         dy_zero_ff <= (dy == '0);
      end
      if (cmd.fetch) begin
         c_ff       <= COS_TAB[cand];
         s_ff       <= SIN_TAB[cand];
         cand_ff    <= cand;
         cand_ok_ff <= (cand <= LAST_DEG);
      end
      if (cmd.mul_hi) acc_lo_ff <= diff_lo;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      lo_ff  <= lo_in;
      eq_ff  <= eq_in;
      bit_ff <= bit_in;
      if (cmd.load_out) begin
         heading_ff  <= heading_in;
         x_offset_ff <= xoff_ff;
         y_offset_ff <= yoff_ff;
      end
   end

   assign heading_deg = heading_ff;
   assign x_offset    = x_offset_ff;
   assign y_offset    = y_offset_ff;

endmodule

[design/compass_heading_with_hard_iron_cal.sv]
// Compass heading with running hard-iron calibration.
//
// The req channel carries one signed X/Y magnetometer sample pair per
// transaction. Every sample widens the running min/max of each axis (the
// first one after reset seeds them); the offset of each axis is the midpoint
// of its extremes. The rsp channel returns, for each sample, the heading of
// the offset-corrected vector in whole degrees 0..359 plus both offsets.
//
// Sequence: after acceptance a transaction passes through the prep and delta
// steps, a seven-step binary search over the degree tables and a finish step
// that loads the output register; the next sample is accepted once that is
// done. Each probe of the search is a table fetch, two passes through the
// shared pair of 17x32 multipliers, and an accumulate and decide.
//
// Reset clears the extremes and the seeded flag and empties the output
// register. The result sits in an output register: a stalled receiver holds
// it, and the block still accepts and works on the next sample, waiting only
// at the end of that work until the register is free.
module compass_heading_with_hard_iron_cal import chc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   chc_req_if.sink   req,
   chc_rsp_if.source rsp
);

   chc_cmd_type  cmd;
   chc_stat_type stat;

   chc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   chc_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .x_sample    (req.x_sample),
      .y_sample    (req.y_sample),
      .heading_deg (rsp.heading_deg),
      .x_offset    (rsp.x_offset),
      .y_offset    (rsp.y_offset)
   );

   // One sample at a time: no acceptance right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while a sample is in work");

   // Heading stays in range
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.heading_deg < DEG_360))
      else $error("heading out of range");

   // Last probe leads straight to loading a free output register
   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.acc && stat.last_probe && !rsp.valid |=> cmd.load_out)
      else $error("search did not end in a result load");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import chc_pkg::*;

   localparam int  SB       = SAMPLE_BITS_DEF;
   localparam int  HALF_CLK = 10;
   localparam int  RST_CYC  = 11;
   localparam int  TAIL_CYC = 40;
   localparam int  MAX_SHOW = 10;
   localparam real PI_R     = 3.14159265358979323846;

   // One expected result: heading plus both hard-iron offsets
   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic [SB-1:0]     x_off;
      logic [SB-1:0]     y_off;
   } fix_type;

   logic clock = 1'b0;
   logic reset;

   chc_req_if #(.SAMPLE_BITS(SB)) req_ch ();
   chc_rsp_if #(.SAMPLE_BITS(SB)) rsp_ch ();

   compass_heading_with_hard_iron_cal #(.SAMPLE_BITS(SB)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Calibration state mirrored from the block
   bit      cal_seeded;
   int      x_hi, x_lo, y_hi, y_lo;
   fix_type due_fixes[$];
   int      mismatches;
   int      idle_pct;
   int      stall_pct;

   always #(HALF_CLK) clock = ~clock;

   // Heading of the corrected vector in whole degrees, truncated
   function automatic logic [HEAD_W-1:0] bearing_of(int dx, int dy);
      int  ax;
      int  ay;
      int  whole;
      bit  on_diag;
      real ang;
      if (dx == 0) return (dy > 0) ? DEG_90 : DEG_270;
      if (dy == 0) return (dx > 0) ? DEG_0 : DEG_180;
      ax      = (dx < 0) ? -dx : dx;
      ay      = (dy < 0) ? -dy : dy;
      on_diag = (ax == ay);
      // only the diagonal lands exactly on a whole degree
      if (on_diag) begin
         whole = 45;
      end else begin
         ang   = $atan2(real'(ay), real'(ax)) * 180.0 / PI_R;
         whole = int'($floor(ang));
      end
      if (dx > 0 && dy > 0) return HEAD_W'(whole);
      if (dx < 0 && dy > 0) return HEAD_W'(on_diag ? 180 - whole : 179 - whole);
      if (dx < 0 && dy < 0) return HEAD_W'(180 + whole);
      return HEAD_W'(on_diag ? 360 - whole : 359 - whole);
   endfunction

   // Widen the extremes, derive offsets and queue the expected fix
   task automatic track_and_bear(input logic signed [SB-1:0] xs,
                                 input logic signed [SB-1:0] ys);
      int      xv;
      int      yv;
      int      xo;
      int      yo;
      fix_type f;
      xv = xs;
      yv = ys;
      if (!cal_seeded) begin
         x_hi       = xv;
         x_lo       = xv;
         y_hi       = yv;
         y_lo       = yv;
         cal_seeded = 1'b1;
      end
      if (xv > x_hi) x_hi = xv;
      else if (xv < x_lo) x_lo = xv;
      if (yv > y_hi) y_hi = yv;
      else if (yv < y_lo) y_lo = yv;
      xo        = (x_hi + x_lo) / 2;
      yo        = (y_hi + y_lo) / 2;
      f.heading = bearing_of(xv - xo, yv - yo);
      f.x_off   = xo[SB-1:0];
      f.y_off   = yo[SB-1:0];
      due_fixes.push_back(f);
   endtask

   // Send one sample pair; entered and left at a falling edge
   task automatic feed_sample(input int x, input int y);
      logic signed [SB-1:0] xs;
      logic signed [SB-1:0] ys;
      xs = x[SB-1:0];
      ys = y[SB-1:0];
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.x_sample <= xs;
      req_ch.y_sample <= ys;
      do @(posedge clock); while (!req_ch.ready);
      track_and_bear(xs, ys);
      @(negedge clock);
   endtask

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_SHOW) $display("%0t: %s", $realtime, what);
   endfunction

   // Hold off the result channel at random
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_fixes
      fix_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_fixes.size() == 0) begin
            note_mismatch($sformatf("unexpected result: heading %0d x_off %0d y_off %0d",
                                    rsp_ch.heading_deg, rsp_ch.x_offset, rsp_ch.y_offset));
         end else begin
            want = due_fixes.pop_front();
            if (rsp_ch.heading_deg !== want.heading)
               note_mismatch($sformatf("heading: expected %0d, got %0d",
                                       want.heading, rsp_ch.heading_deg));
            if (rsp_ch.x_offset !== want.x_off)
               note_mismatch($sformatf("x_offset: expected %0d, got %0d",
                                       $signed(want.x_off), rsp_ch.x_offset));
            if (rsp_ch.y_offset !== want.y_off)
               note_mismatch($sformatf("y_offset: expected %0d, got %0d",
                                       $signed(want.y_off), rsp_ch.y_offset));
         end
      end
   end

   // First sample after reset seeds all extremes: zero vector, offsets equal the sample
   task automatic test_first_sample_seed();
      feed_sample(1234, -567);
   endtask

   // Widen both axes, then stay inside the extremes
   task automatic test_offset_tracking();
      feed_sample(-20000, -20000);
      feed_sample(20000, 20000);
      feed_sample(5000, -3000);
   endtask

   // Zero X component, zero Y component and the zero vector
   task automatic test_axis_headings();
      feed_sample(0, 100);
      feed_sample(0, -100);
      feed_sample(100, 0);
      feed_sample(-100, 0);
      feed_sample(0, 0);
   endtask

   // Exact diagonals in all four quadrants
   task automatic test_diagonals();
      feed_sample(300, 300);
      feed_sample(-300, 300);
      feed_sample(-300, -300);
      feed_sample(300, -300);
   endtask

   // Fractional angles folded into each quadrant
   task automatic test_quadrant_folds();
      feed_sample(1000, 17);
      feed_sample(-1000, 17);
      feed_sample(-17, -1000);
      feed_sample(17, -1000);
   endtask

   // Largest and smallest sample on each axis
   task automatic test_field_extremes();
      feed_sample(32767, 0);
      feed_sample(-32768, 0);
      feed_sample(0, 32767);
      feed_sample(0, -32768);
      feed_sample(32767, -32768);
      feed_sample(-32768, 32767);
   endtask

   // Random samples: full range, small vectors, diagonals, axes, near-axis, random widths
   task automatic test_random_samples(input int count, input int idle, input int stall);
      int x;
      int y;
      int m;
      int w;
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               x = $urandom;
               y = $urandom;
            end
            4, 5: begin
               x = int'($urandom_range(0, 8)) - 4;
               y = int'($urandom_range(0, 8)) - 4;
            end
            6: begin
               m = $urandom_range(1, 32767);
               x = $urandom_range(0, 1) ? -m : m;
               y = $urandom_range(0, 1) ? -m : m;
            end
            7: begin
               m = $urandom;
               x = $urandom_range(0, 1) ? m : 0;
               y = (x == 0) ? m : 0;
            end
            8: begin
               m = $urandom_range(1, 3);
               x = $urandom;
               y = $urandom_range(0, 1) ? -m : m;
               if ($urandom_range(0, 1)) begin
                  w = x;
                  x = y;
                  y = w;
               end
            end
            default: begin
               w = $urandom_range(1, SB);
               x = $signed(SB'($urandom)) >>> (SB - w);
               y = $signed(SB'($urandom)) >>> (SB - $urandom_range(1, SB));
            end
         endcase
         feed_sample(x, y);
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.x_sample <= '0;
      req_ch.y_sample <= '0;
      idle_pct   = 0;
      stall_pct  = 0;
      mismatches = 0;
      cal_seeded = 1'b0;
      x_hi = 0;
      x_lo = 0;
      y_hi = 0;
      y_lo = 0;
      repeat (RST_CYC) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_sample_seed();
      test_offset_tracking();
      test_axis_headings();
      test_diagonals();
      test_quadrant_folds();
      test_field_extremes();

      test_random_samples(100, 0, 0);
      test_random_samples(100, 46, 0);
      test_random_samples(100, 0, 46);
      test_random_samples(100, 19, 19);

      // drop valid and drain the outstanding results
      req_ch.valid <= 1'b0;
      while (due_fixes.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
      if (mismatches == 0 && due_fixes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #(10_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
